// ===== hw/rtl/cpualu_pkg.sv =====
// shared types, widths and operation codes of the cpu alu
`default_nettype none

package cpualu_pkg;

  localparam int ACTION_W = 5;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int TOP_BIT  = BYTE_W - 1;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 5'd0;
  localparam logic [ACTION_W-1:0] ACT_ADC   = 5'd1;
  localparam logic [ACTION_W-1:0] ACT_SUB   = 5'd2;
  localparam logic [ACTION_W-1:0] ACT_SBC   = 5'd3;
  localparam logic [ACTION_W-1:0] ACT_AND   = 5'd4;
  localparam logic [ACTION_W-1:0] ACT_XOR   = 5'd5;
  localparam logic [ACTION_W-1:0] ACT_OR    = 5'd6;
  localparam logic [ACTION_W-1:0] ACT_CP    = 5'd7;
  localparam logic [ACTION_W-1:0] ACT_INC   = 5'd8;
  localparam logic [ACTION_W-1:0] ACT_DEC   = 5'd9;
  localparam logic [ACTION_W-1:0] ACT_RLC   = 5'd10;
  localparam logic [ACTION_W-1:0] ACT_RRC   = 5'd11;
  localparam logic [ACTION_W-1:0] ACT_RL    = 5'd12;
  localparam logic [ACTION_W-1:0] ACT_RR    = 5'd13;
  localparam logic [ACTION_W-1:0] ACT_CPL   = 5'd14;
  localparam logic [ACTION_W-1:0] ACT_SCF   = 5'd15;
  localparam logic [ACTION_W-1:0] ACT_CCF   = 5'd16;
  localparam logic [ACTION_W-1:0] ACT_ADD16 = 5'd17;
  localparam logic [ACTION_W-1:0] ACT_ADDSP = 5'd18;

  typedef struct packed {
    logic              zero;
    logic              subtract;
    logic              half;
    logic              carry;
  } flags_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   acc_byte;
    logic [BYTE_W-1:0]   operand_byte;
    logic [WORD_W-1:0]   base_word;
    logic [WORD_W-1:0]   addend_word;
    flags_t              flags;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic [WORD_W-1:0] result_word;
    flags_t            flags;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpualu_core.sv =====
// combinational datapath and flag logic of the cpu alu
`default_nettype none

module cpualu_core (
  input  cpualu_pkg::op_t  op,
  output cpualu_pkg::res_t res
);

  logic [cpualu_pkg::BYTE_W-1:0] a;
  logic [cpualu_pkg::BYTE_W-1:0] b;
  logic                          ci;
  logic                          bi;
  logic [cpualu_pkg::BYTE_W:0]   add9;
  logic [4:0]                    addh5;
  logic [cpualu_pkg::BYTE_W:0]   sub9;
  logic [4:0]                    subh5;
  logic [cpualu_pkg::WORD_W:0]   w17;
  logic [12:0]                   wh13;
  logic [cpualu_pkg::WORD_W-1:0] spw;
  logic [4:0]                    sph5;
  logic [cpualu_pkg::BYTE_W:0]   spc9;
  logic [cpualu_pkg::BYTE_W-1:0] rot;

  assign a  = op.acc_byte;
  assign b  = op.operand_byte;
  assign ci = (op.action == cpualu_pkg::ACT_ADC) & op.flags.carry;
  assign bi = (op.action == cpualu_pkg::ACT_SBC) & op.flags.carry;

  // byte add / subtract with nibble carry and borrow
  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, bi};
  assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, bi};

  // 16-bit adds
  assign w17  = {1'b0, op.base_word} + {1'b0, op.addend_word};
  assign wh13 = {1'b0, op.base_word[11:0]} + {1'b0, op.addend_word[11:0]};
  assign spw  = op.base_word + {{8{b[cpualu_pkg::TOP_BIT]}}, b};
  assign sph5 = {1'b0, op.base_word[3:0]} + {1'b0, b[3:0]};
  assign spc9 = {1'b0, op.base_word[7:0]} + {1'b0, b};

  always_comb begin
    res             = '0;
    res.result_byte = a;
    res.flags       = op.flags;
    rot             = a;
    case (op.action)
      cpualu_pkg::ACT_ADD, cpualu_pkg::ACT_ADC: begin
        res.result_byte    = add9[7:0];
        res.flags.zero     = (add9[7:0] == 8'd0);
        res.flags.subtract = 1'b0;
        res.flags.half     = addh5[4];
        res.flags.carry    = add9[8];
      end
      cpualu_pkg::ACT_SUB, cpualu_pkg::ACT_SBC, cpualu_pkg::ACT_CP: begin
        if (op.action != cpualu_pkg::ACT_CP) begin
          res.result_byte = sub9[7:0];
        end
        res.flags.zero     = (sub9[7:0] == 8'd0);
        res.flags.subtract = 1'b1;
        res.flags.half     = subh5[4];
        res.flags.carry    = sub9[8];
      end
      cpualu_pkg::ACT_AND: begin
        res.result_byte = a & b;
        res.flags       = '{zero: ((a & b) == 8'd0), subtract: 1'b0, half: 1'b1, carry: 1'b0};
      end
      cpualu_pkg::ACT_XOR: begin
        res.result_byte = a ^ b;
        res.flags       = '{zero: ((a ^ b) == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      cpualu_pkg::ACT_OR: begin
        res.result_byte = a | b;
        res.flags       = '{zero: ((a | b) == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      cpualu_pkg::ACT_INC: begin
        res.result_byte    = a + 8'd1;
        res.flags.zero     = (a == 8'hff);
        res.flags.subtract = 1'b0;
        res.flags.half     = &a[3:0];
      end
      cpualu_pkg::ACT_DEC: begin
        res.result_byte    = a - 8'd1;
        res.flags.zero     = (a == 8'd1);
        res.flags.subtract = 1'b1;
        res.flags.half     = (a[3:0] == 4'd0);
      end
      cpualu_pkg::ACT_RLC, cpualu_pkg::ACT_RRC, cpualu_pkg::ACT_RL,
      cpualu_pkg::ACT_RR: begin
        case (op.action)
          cpualu_pkg::ACT_RLC: rot = {a[6:0], a[cpualu_pkg::TOP_BIT]};
          cpualu_pkg::ACT_RRC: rot = {a[0], a[7:1]};
          cpualu_pkg::ACT_RL:  rot = {a[6:0], op.flags.carry};
          default:             rot = {op.flags.carry, a[7:1]};
        endcase
        res.result_byte    = rot;
        res.flags.zero     = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        // left rotates shift out the top bit, right rotates the bottom bit
        res.flags.carry    = (op.action == cpualu_pkg::ACT_RLC ||
                              op.action == cpualu_pkg::ACT_RL) ?
                             a[cpualu_pkg::TOP_BIT] : a[0];
      end
      cpualu_pkg::ACT_CPL: begin
        res.result_byte    = ~a;
        res.flags.subtract = 1'b1;
        res.flags.half     = 1'b1;
      end
      cpualu_pkg::ACT_SCF: begin
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        res.flags.carry    = 1'b1;
      end
      cpualu_pkg::ACT_CCF: begin
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        res.flags.carry    = ~op.flags.carry;
      end
      cpualu_pkg::ACT_ADD16: begin
        res.result_word    = w17[15:0];
        res.flags.subtract = 1'b0;
        res.flags.half     = wh13[12];
        res.flags.carry    = w17[16];
      end
      cpualu_pkg::ACT_ADDSP: begin
        res.result_word    = spw;
        res.flags.zero     = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = sph5[4];
        res.flags.carry    = spc9[8];
      end
      default: begin
        // unused codes pass the accumulator byte and the flags through; the word result is zero
        res.result_byte = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/eight_bit_cpu_alu_with_flags.sv =====
// top level of the 8-bit cpu alu: input register, alu core, result register
//
// usage:
//   input channel  in_valid / in_ready carries one word per operation: action
//   code, accumulator byte, operand byte, two 16-bit words and the z/n/h/c flags
//   result channel out_valid / out_ready carries the byte result, the word
//   result and the new flags
//   path: an accepted word waits in the input register and moves into the result
//   register once that register is free, where it shows on the result ports
//   throughput: one word per cycle unless out_ready stalls; the input register
//   and the result register each hold one word, so a new word is taken while an earlier one waits
//   the only work between the two registers is the alu core (8/16-bit adds,
//   logic ops, rotates and flag selection)
//   stall: when out_ready is low the result holds; the input register keeps
//   filling, and in_ready drops only once both registers are full
//   reset: rst_n is synchronous, active low; both valid bits clear, so the
//   block comes out of reset empty and ready
`default_nettype none

module eight_bit_cpu_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_action,
  input  wire logic [7:0]  in_acc_byte,
  input  wire logic [7:0]  in_operand_byte,
  input  wire logic [15:0] in_base_word,
  input  wire logic [15:0] in_addend_word,
  input  wire logic        in_zero_in,
  input  wire logic        in_subtract_in,
  input  wire logic        in_half_in,
  input  wire logic        in_carry_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result_byte,
  output logic [15:0]      out_result_word,
  output logic             out_zero_out,
  output logic             out_subtract_out,
  output logic             out_half_out,
  output logic             out_carry_out
);

  // input register stage
  logic             op_vld_r;
  logic             op_vld_nxt;
  cpualu_pkg::op_t  op_r;
  cpualu_pkg::op_t  op_in;
  logic             op_load;

  // result register stage
  logic             res_vld_r;
  logic             res_vld_nxt;
  cpualu_pkg::res_t res_r;
  cpualu_pkg::res_t res_comb;
  logic             res_load;
  logic             op_ready;

  // pack the incoming word
  assign op_in.action         = in_action;
  assign op_in.acc_byte       = in_acc_byte;
  assign op_in.operand_byte   = in_operand_byte;
  assign op_in.base_word      = in_base_word;
  assign op_in.addend_word    = in_addend_word;
  assign op_in.flags.zero     = in_zero_in;
  assign op_in.flags.subtract = in_subtract_in;
  assign op_in.flags.half     = in_half_in;
  assign op_in.flags.carry    = in_carry_in;

  // result register frees up when empty or being taken this cycle
  assign op_ready = ~res_vld_r | out_ready;
  assign res_load = op_vld_r & op_ready;

  // input register frees up when empty or moving on to the result register
  assign in_ready = ~op_vld_r | op_ready;
  assign op_load  = in_valid & in_ready;

  always_comb begin
    op_vld_nxt = op_vld_r;
    if (op_load) begin
      op_vld_nxt = 1'b1;
    end else if (res_load) begin
      op_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (res_load) begin
      res_vld_nxt = 1'b1;
    end else if (out_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      op_vld_r  <= op_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (op_load) begin
      op_r <= op_in;
    end
    if (res_load) begin
      res_r <= res_comb;
    end
  end

  cpualu_core u_core (
    .op  (op_r),
    .res (res_comb)
  );

  assign out_valid        = res_vld_r;
  assign out_result_byte  = res_r.result_byte;
  assign out_result_word  = res_r.result_word;
  assign out_zero_out     = res_r.flags.zero;
  assign out_subtract_out = res_r.flags.subtract;
  assign out_half_out     = res_r.flags.half;
  assign out_carry_out    = res_r.flags.carry;

endmodule

`default_nettype wire

// ===== hw/rtl/cpualu_checker.sv =====
// port-level assertions for the cpu alu and their bind to the top level
`default_nettype none

module cpualu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_result_byte,
  input wire logic [15:0] out_result_word
);

  // reset leaves the result channel empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result pending the block always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  // an accepted word reaches the result port when out_ready does not stall it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after accept");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_byte) && $stable(out_result_word))
    else $error("result changed while stalled");

endmodule

bind eight_bit_cpu_alu_with_flags cpualu_checker u_cpualu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_byte (out_result_byte),
  .out_result_word (out_result_word)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the 8-bit cpu alu: directed and random words, scoreboard check
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_WORDS   = 1350;
  localparam int STALL_PCT      = 20;
  localparam int STEADY_FIRST   = 400;  // no idling on either side from here
  localparam int STEADY_LAST    = 699;  // up to here
  localparam int DRAIN_AT       = 900;  // sender holds off here until all results are back
  localparam int TAIL_CYCLES    = 6;    // idle margin after the final drain
  localparam int WATCHDOG_LIMIT = 2000;

  // action codes past the last real operation do nothing
  localparam logic [cpualu_pkg::ACTION_W-1:0] ACT_FIRST_UNUSED = 5'd19;
  localparam logic [cpualu_pkg::ACTION_W-1:0] ACT_LAST_UNUSED  = 5'd31;

  // golden model of the alu plus the queue of results still owed by the block
  class alu_scoreboard;
    cpualu_pkg::res_t pending_results[$];
    int               error_count = 0;

    function cpualu_pkg::res_t alu_outcome(cpualu_pkg::op_t op);
      cpualu_pkg::res_t r;
      logic             ci;
      logic [8:0]       sum9;
      logic [4:0]       nib;
      logic [12:0]      sum13;
      logic [16:0]      sum17;
      logic [15:0]      offset;
      r.result_byte = op.acc_byte;
      r.result_word = '0;
      r.flags       = op.flags;
      case (op.action)
        cpualu_pkg::ACT_ADD, cpualu_pkg::ACT_ADC: begin
          ci = (op.action == cpualu_pkg::ACT_ADC) ? op.flags.carry : 1'b0;
          sum9 = {1'b0, op.acc_byte} + {1'b0, op.operand_byte} + {8'd0, ci};
          nib = {1'b0, op.acc_byte[3:0]} + {1'b0, op.operand_byte[3:0]} + {4'd0, ci};
          r.result_byte    = sum9[7:0];
          r.flags.zero     = (sum9[7:0] == 8'h00);
          r.flags.subtract = 1'b0;
          r.flags.half     = nib[4];
          r.flags.carry    = sum9[8];
        end
        cpualu_pkg::ACT_SUB, cpualu_pkg::ACT_SBC, cpualu_pkg::ACT_CP: begin
          // borrow shows up as the extra top bit of the wider difference
          ci = (op.action == cpualu_pkg::ACT_SBC) ? op.flags.carry : 1'b0;
          sum9 = {1'b0, op.acc_byte} - {1'b0, op.operand_byte} - {8'd0, ci};
          nib = {1'b0, op.acc_byte[3:0]} - {1'b0, op.operand_byte[3:0]} - {4'd0, ci};
          if (op.action != cpualu_pkg::ACT_CP) r.result_byte = sum9[7:0];
          r.flags.zero     = (sum9[7:0] == 8'h00);
          r.flags.subtract = 1'b1;
          r.flags.half     = nib[4];
          r.flags.carry    = sum9[8];
        end
        cpualu_pkg::ACT_AND, cpualu_pkg::ACT_XOR, cpualu_pkg::ACT_OR: begin
          if (op.action == cpualu_pkg::ACT_AND) begin
            r.result_byte = op.acc_byte & op.operand_byte;
          end else if (op.action == cpualu_pkg::ACT_XOR) begin
            r.result_byte = op.acc_byte ^ op.operand_byte;
          end else begin
            r.result_byte = op.acc_byte | op.operand_byte;
          end
          r.flags.zero     = (r.result_byte == 8'h00);
          r.flags.subtract = 1'b0;
          r.flags.half     = (op.action == cpualu_pkg::ACT_AND);
          r.flags.carry    = 1'b0;
        end
        cpualu_pkg::ACT_INC: begin
          r.result_byte    = op.acc_byte + 8'd1;
          r.flags.zero     = (r.result_byte == 8'h00);
          r.flags.subtract = 1'b0;
          r.flags.half     = (op.acc_byte[3:0] == 4'hf);
        end
        cpualu_pkg::ACT_DEC: begin
          r.result_byte    = op.acc_byte - 8'd1;
          r.flags.zero     = (r.result_byte == 8'h00);
          r.flags.subtract = 1'b1;
          r.flags.half     = (op.acc_byte[3:0] == 4'h0);
        end
        cpualu_pkg::ACT_RLC, cpualu_pkg::ACT_RRC, cpualu_pkg::ACT_RL,
        cpualu_pkg::ACT_RR: begin
          case (op.action)
            cpualu_pkg::ACT_RLC: r.result_byte = {op.acc_byte[6:0], op.acc_byte[7]};
            cpualu_pkg::ACT_RRC: r.result_byte = {op.acc_byte[0], op.acc_byte[7:1]};
            cpualu_pkg::ACT_RL:  r.result_byte = {op.acc_byte[6:0], op.flags.carry};
            default:             r.result_byte = {op.flags.carry, op.acc_byte[7:1]};
          endcase
          r.flags.zero     = 1'b0;
          r.flags.subtract = 1'b0;
          r.flags.half     = 1'b0;
          r.flags.carry    = (op.action == cpualu_pkg::ACT_RLC ||
                              op.action == cpualu_pkg::ACT_RL) ?
                             op.acc_byte[7] : op.acc_byte[0];
        end
        cpualu_pkg::ACT_CPL: begin
          r.result_byte    = ~op.acc_byte;
          r.flags.subtract = 1'b1;
          r.flags.half     = 1'b1;
        end
        cpualu_pkg::ACT_SCF, cpualu_pkg::ACT_CCF: begin
          r.flags.subtract = 1'b0;
          r.flags.half     = 1'b0;
          r.flags.carry    = (op.action == cpualu_pkg::ACT_SCF) ? 1'b1 : ~op.flags.carry;
        end
        cpualu_pkg::ACT_ADD16: begin
          sum17 = {1'b0, op.base_word} + {1'b0, op.addend_word};
          sum13 = {1'b0, op.base_word[11:0]} + {1'b0, op.addend_word[11:0]};
          r.result_word    = sum17[15:0];
          r.flags.subtract = 1'b0;
          r.flags.half     = sum13[12];
          r.flags.carry    = sum17[16];
        end
        cpualu_pkg::ACT_ADDSP: begin
          // word uses the sign-extended offset, flags the unsigned low byte
          offset = {{8{op.operand_byte[7]}}, op.operand_byte};
          sum9 = {1'b0, op.base_word[7:0]} + {1'b0, op.operand_byte};
          nib = {1'b0, op.base_word[3:0]} + {1'b0, op.operand_byte[3:0]};
          r.result_word    = op.base_word + offset;
          r.flags.zero     = 1'b0;
          r.flags.subtract = 1'b0;
          r.flags.half     = nib[4];
          r.flags.carry    = sum9[8];
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_op(cpualu_pkg::op_t op);
      pending_results.push_back(alu_outcome(op));
    endfunction

    function void check_result(cpualu_pkg::res_t got);
      cpualu_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: byte %h word %h flags %b",
               got.result_byte, got.result_word, got.flags);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_byte !== want.result_byte) begin
        $error("result_byte: expected %h, got %h", want.result_byte, got.result_byte);
        error_count++;
      end
      if (got.result_word !== want.result_word) begin
        $error("result_word: expected %h, got %h", want.result_word, got.result_word);
        error_count++;
      end
      if (got.flags.zero !== want.flags.zero) begin
        $error("zero_out: expected %b, got %b", want.flags.zero, got.flags.zero);
        error_count++;
      end
      if (got.flags.subtract !== want.flags.subtract) begin
        $error("subtract_out: expected %b, got %b", want.flags.subtract, got.flags.subtract);
        error_count++;
      end
      if (got.flags.half !== want.flags.half) begin
        $error("half_out: expected %b, got %b", want.flags.half, got.flags.half);
        error_count++;
      end
      if (got.flags.carry !== want.flags.carry) begin
        $error("carry_out: expected %b, got %b", want.flags.carry, got.flags.carry);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_action;
  logic [7:0]  in_acc_byte;
  logic [7:0]  in_operand_byte;
  logic [15:0] in_base_word;
  logic [15:0] in_addend_word;
  logic        in_zero_in;
  logic        in_subtract_in;
  logic        in_half_in;
  logic        in_carry_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_result_byte;
  logic [15:0] out_result_word;
  logic        out_zero_out;
  logic        out_subtract_out;
  logic        out_half_out;
  logic        out_carry_out;

  cpualu_pkg::op_t  seen_op;
  cpualu_pkg::res_t seen_res;
  alu_scoreboard    sb;
  bit               steady;       // set while neither side is allowed to idle
  int               idle_cycles;  // cycles since the last handshake on either channel

  eight_bit_cpu_alu_with_flags i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_acc_byte      (in_acc_byte),
    .in_operand_byte  (in_operand_byte),
    .in_base_word     (in_base_word),
    .in_addend_word   (in_addend_word),
    .in_zero_in       (in_zero_in),
    .in_subtract_in   (in_subtract_in),
    .in_half_in       (in_half_in),
    .in_carry_in      (in_carry_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_byte  (out_result_byte),
    .out_result_word  (out_result_word),
    .out_zero_out     (out_zero_out),
    .out_subtract_out (out_subtract_out),
    .out_half_out     (out_half_out),
    .out_carry_out    (out_carry_out)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // port bundles in the package's packed layout, flags with zero on top
  assign seen_op  = {in_action, in_acc_byte, in_operand_byte, in_base_word, in_addend_word,
                     in_zero_in, in_subtract_in, in_half_in, in_carry_in};
  assign seen_res = {out_result_byte, out_result_word,
                     out_zero_out, out_subtract_out, out_half_out, out_carry_out};

  // monitor: values seen here are the ones from just before the edge, so a
  // handshake is exactly valid && ready at this edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_op(seen_op);
    if (rst_n && out_valid && out_ready) sb.check_result(seen_res);
  end

  // receiver: stalls at random, about 20 percent of the time, unless a steady stretch is running
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // watchdog: give up when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cpualu_pkg::op_t make_op(logic [4:0] action, logic [7:0] a,
                                              logic [7:0] b, logic [15:0] base,
                                              logic [15:0] addend, logic [3:0] fl);
    cpualu_pkg::op_t op;
    op.action       = action;
    op.acc_byte     = a;
    op.operand_byte = b;
    op.base_word    = base;
    op.addend_word  = addend;
    op.flags        = fl;
    return op;
  endfunction

  // byte values lean toward nibble and sign boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h0f;
      3: return 8'h10;
      4: return 8'h80;
      5: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0fff;
      3: return 16'h00ff;
      4: return 16'h8000;
      5: return 16'h000f;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cpualu_pkg::op_t random_op();
    logic [4:0] action;
    logic [3:0] fl;
    // roughly one word in ten carries an unused action code
    if ($urandom_range(0, 9) == 0) begin
      action = 5'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    end else begin
      action = 5'($urandom_range(cpualu_pkg::ACT_ADD, cpualu_pkg::ACT_ADDSP));
    end
    fl = 4'($urandom_range(0, 15));
    return make_op(action, pick_byte(), pick_byte(), pick_word(), pick_word(), fl);
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_op(cpualu_pkg::op_t op);
    in_valid        <= 1'b1;
    in_action       <= op.action;
    in_acc_byte     <= op.acc_byte;
    in_operand_byte <= op.operand_byte;
    in_base_word    <= op.base_word;
    in_addend_word  <= op.addend_word;
    in_zero_in      <= op.flags.zero;
    in_subtract_in  <= op.flags.subtract;
    in_half_in      <= op.flags.half;
    in_carry_in     <= op.flags.carry;
    do @(posedge clk); while (!in_ready);
  endtask

  // random gap after a word, lowering valid only when the gap is taken
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    cpualu_pkg::op_t directed_ops[$];
    sb = new;
    steady = 1'b0;
    idle_cycles = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= cpualu_pkg::ACT_ADD;
    in_acc_byte     <= '0;
    in_operand_byte <= '0;
    in_base_word    <= '0;
    in_addend_word  <= '0;
    in_zero_in      <= 1'b0;
    in_subtract_in  <= 1'b0;
    in_half_in      <= 1'b0;
    in_carry_in     <= 1'b0;
    out_ready       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: flag corners of every operation, flags ordered z n h c
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADD, 8'hff, 8'h01, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADC, 8'h0f, 8'h00, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADC, 8'hff, 8'hff, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_SUB, 8'h42, 8'h42, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_SUB, 8'h10, 8'h01, '0, '0, 4'b1111));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_SBC, 8'h00, 8'h00, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_CP,  8'h3c, 8'h40, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_AND, 8'hf0, 8'h0f, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_XOR, 8'h5a, 8'h5a, '0, '0, 4'b1111));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_OR,  8'h00, 8'h00, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_INC, 8'hff, 8'h00, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_INC, 8'h0f, 8'h00, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_DEC, 8'h01, 8'h00, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_DEC, 8'h10, 8'h00, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_RLC, 8'h80, 8'h00, '0, '0, 4'b1110));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_RRC, 8'h01, 8'h00, '0, '0, 4'b1110));
    // zero byte from rl, z stays clear
    directed_ops.push_back(make_op(cpualu_pkg::ACT_RL,  8'h80, 8'h00, '0, '0, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_RR,  8'h01, 8'h00, '0, '0, 4'b0001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_CPL, 8'h35, 8'h00, '0, '0, 4'b1001));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_SCF, 8'ha5, 8'h00, '0, '0, 4'b0110));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_CCF, 8'ha5, 8'h00, '0, '0, 4'b1111));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADD16, 8'h12, 8'h00,
                                   16'hffff, 16'h0001, 4'b1111));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADD16, 8'h12, 8'h00,
                                   16'h0fff, 16'h0001, 4'b0000));
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADDSP, 8'h00, 8'h01,
                                   16'hffff, '0, 4'b1111));
    // offset of minus 128
    directed_ops.push_back(make_op(cpualu_pkg::ACT_ADDSP, 8'h00, 8'h80,
                                   16'h0000, '0, 4'b1111));
    directed_ops.push_back(make_op(ACT_LAST_UNUSED, 8'hc3, 8'hff,
                                   16'hffff, 16'hffff, 4'b1111));
    foreach (directed_ops[k]) begin
      send_op(directed_ops[k]);
      if (k == directed_ops.size() - 1) wait_drained();
      else sender_gap();
    end

    // random words with a steady stretch and one full drain in the middle
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= STEADY_FIRST && i <= STEADY_LAST);
      send_op(random_op());
      if (i == DRAIN_AT || i == RANDOM_WORDS - 1) wait_drained();
      else sender_gap();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
